@@ sv/afc_pkg.sv @@
`default_nettype none

package afc_pkg;

	localparam int NUM_PLANES = 6;
	localparam int NUM_AXES   = 3;
	localparam int WORD_W     = 64;
	localparam int CTR_W      = 16;
	localparam int HALF_W     = 15;

	localparam int ROW_LSB  = 0;
	localparam int CTR_LSB  = ROW_LSB + NUM_AXES * WORD_W;
	localparam int HALF_LSB = CTR_LSB + NUM_AXES * CTR_W;
	localparam int IN_BITS  = HALF_LSB + NUM_AXES * HALF_W;

	localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = 8;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_PLANE_NEAR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANE_FAR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANE_LEFT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANE_RIGHT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANE_TOP    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANE_BOTTOM = 3'd5;

	// Load strobes for the two plane stages.
	typedef struct packed {
		logic ld_s3;
		logic ld_s4;
	} afc_stage_en_t;

endpackage

`default_nettype wire

@@ sv/afc_plane_test.sv @@
`default_nettype none

module afc_plane_test #(
	parameter int VW = 16,
	parameter int CW = 34,
	parameter int HW = 33,
	parameter int TW = 53
) (
	input  wire                         clk,
	input  wire afc_pkg::afc_stage_en_t en,
	input  wire logic signed [VW-1:0]   n [afc_pkg::NUM_AXES],
	input  wire logic signed [VW-1:0]   d,
	input  wire logic signed [CW-1:0]   wc [afc_pkg::NUM_AXES],
	input  wire logic        [HW-1:0]   wh [afc_pkg::NUM_AXES],
	output logic                        lt_s4
);

	logic        [VW-1:0] magn   [afc_pkg::NUM_AXES];
	logic signed [TW-1:0] pn_d   [afc_pkg::NUM_AXES];
	logic        [TW-1:0] pr_d   [afc_pkg::NUM_AXES];
	logic signed [TW-1:0] pn_s3  [afc_pkg::NUM_AXES];
	logic        [TW-1:0] pr_s3  [afc_pkg::NUM_AXES];
	logic signed [VW-1:0] d_s3;
	logic signed [TW-1:0] sdist;
	logic        [TW-1:0] rad;
	logic        [TW-1:0] neg_rad;

	always_comb begin
		for (int j = 0; j < afc_pkg::NUM_AXES; j++) begin
			magn[j] = n[j][VW-1] ? (~n[j] + 1'b1) : n[j];
			pn_d[j] = TW'(n[j]) * TW'(wc[j]);
			pr_d[j] = TW'(magn[j]) * TW'(wh[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_s3) begin
			pn_s3 <= pn_d;
			pr_s3 <= pr_d;
			d_s3  <= d;
		end
	end

	always_comb begin
		sdist   = pn_s3[0] + pn_s3[1] + pn_s3[2] + (TW'(d_s3) <<< 24);
		rad     = pr_s3[0] + pr_s3[1] + pr_s3[2];
		neg_rad = TW'(0) - rad;
	end

	always_ff @(posedge clk) begin
		if (en.ld_s4) begin
			lt_s4 <= sdist < $signed(neg_rad);
		end
	end

endmodule

`default_nettype wire

@@ sv/aabb_frustum_cull.sv @@
// Throughput: one box per cycle unless m_tready stalls; four compute stages and an output register.
// Stages: local products, world center and extents, plane products, plane sums and compare.
// Reset clears every stage valid bit, the output valid and all six planes to zero.
// After reset no box is culled until a plane is written.
`default_nettype none

module aabb_frustum_cull #(
	parameter int VALUE_WIDTH = 16
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// Fields from bit 0: matrix_row_x, matrix_row_y, matrix_row_z, center_x, center_y,
	// center_z, half_x, half_y, half_z, zero fill.
	input  wire  [afc_pkg::S_TDATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// Fields from bit 0: culled, zero fill.
	output logic [afc_pkg::M_TDATA_W-1:0]     m_tdata,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [afc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [afc_pkg::WORD_W-1:0]        cfg_data
);

	localparam int VW  = VALUE_WIDTH;
	localparam int XW  = (4 * VW > afc_pkg::WORD_W) ? 4 * VW : afc_pkg::WORD_W;
	localparam int MCW = VW + afc_pkg::CTR_W;
	localparam int MHW = VW + afc_pkg::HALF_W;
	localparam int CW  = VW + 18;
	localparam int HW  = VW + 17;
	localparam int TW  = (2 * VW + 21 > afc_pkg::WORD_W) ? afc_pkg::WORD_W : 2 * VW + 21;
	localparam int NA  = afc_pkg::NUM_AXES;
	localparam int NP  = afc_pkg::NUM_PLANES;

	function automatic logic [VW-1:0] lane_of(input logic [afc_pkg::WORD_W-1:0] word,
			input logic [1:0] k);
		logic [XW-1:0] x;
		x = XW'(word);
		lane_of = x[k*VW +: VW];
	endfunction

	logic [afc_pkg::WORD_W-1:0] plane_q [NP];

	logic [afc_pkg::WORD_W-1:0]        row_in  [NA];
	logic signed [afc_pkg::CTR_W-1:0]  ctr_in  [NA];
	logic [afc_pkg::HALF_W-1:0]        half_in [NA];

	logic signed [MCW-1:0] mc_d  [NA][NA];
	logic        [MHW-1:0] mh_d  [NA][NA];
	logic signed [VW-1:0]  t_d   [NA];
	logic signed [MCW-1:0] mc_s1 [NA][NA];
	logic        [MHW-1:0] mh_s1 [NA][NA];
	logic signed [VW-1:0]  t_s1  [NA];

	logic signed [CW-1:0]  wc_d  [NA];
	logic        [HW-1:0]  wh_d  [NA];
	logic signed [CW-1:0]  wc_s2 [NA];
	logic        [HW-1:0]  wh_s2 [NA];

	logic signed [VW-1:0]  pl_n [NP][NA];
	logic signed [VW-1:0]  pl_d [NP];
	logic        [NP-1:0]  lt_s4;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4, rdy_o;
	logic culled_q;
	afc_pkg::afc_stage_en_t stage_en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NP; p++) begin
				plane_q[p] <= '0;
			end
		end else if (cfg_valid && cfg_index <= afc_pkg::CFG_PLANE_BOTTOM) begin
			plane_q[cfg_index] <= cfg_data;
		end
	end

	assign rdy_o    = !m_tvalid || m_tready;
	assign rdy4     = !v_s4 || rdy_o;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;

	assign stage_en.ld_s3 = rdy3 && v_s2;
	assign stage_en.ld_s4 = rdy4 && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy_o) m_tvalid <= v_s4;
		end
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_in[i]  = s_tdata[afc_pkg::ROW_LSB + i*afc_pkg::WORD_W +: afc_pkg::WORD_W];
			ctr_in[i]  = s_tdata[afc_pkg::CTR_LSB + i*afc_pkg::CTR_W +: afc_pkg::CTR_W];
			half_in[i] = s_tdata[afc_pkg::HALF_LSB + i*afc_pkg::HALF_W +: afc_pkg::HALF_W];
		end
	end

	// Stage 1: the matrix times the local center and times the half extents, nine products each.
	always_comb begin
		logic [VW-1:0] m;
		logic [VW-1:0] magm;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NA; j++) begin
				m          = lane_of(row_in[i], 2'(j));
				magm       = m[VW-1] ? (~m + 1'b1) : m;
				mc_d[i][j] = MCW'($signed(m)) * MCW'(ctr_in[j]);
				mh_d[i][j] = MHW'(magm) * MHW'(half_in[j]);
			end
			t_d[i] = $signed(lane_of(row_in[i], 2'd3));
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			mc_s1 <= mc_d;
			mh_s1 <= mh_d;
			t_s1  <= t_d;
		end
	end

	// Stage 2: world center and world half extents.
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			wc_d[i] = CW'(mc_s1[i][0]) + CW'(mc_s1[i][1]) + CW'(mc_s1[i][2])
				+ (CW'(t_s1[i]) <<< 12);
			wh_d[i] = HW'(mh_s1[i][0]) + HW'(mh_s1[i][1]) + HW'(mh_s1[i][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			wc_s2 <= wc_d;
			wh_s2 <= wh_d;
		end
	end

	always_comb begin
		for (int p = 0; p < NP; p++) begin
			for (int j = 0; j < NA; j++) begin
				pl_n[p][j] = $signed(lane_of(plane_q[p], 2'(j)));
			end
			pl_d[p] = $signed(lane_of(plane_q[p], 2'd3));
		end
	end

	// Stages 3 and 4: one test unit per plane.
	for (genvar p = 0; p < NP; p++) begin : g_plane
		afc_plane_test #(
			.VW (VW),
			.CW (CW),
			.HW (HW),
			.TW (TW)
		) u_test (
			.clk   (clk),
			.en    (stage_en),
			.n     (pl_n[p]),
			.d     (pl_d[p]),
			.wc    (wc_s2),
			.wh    (wh_s2),
			.lt_s4 (lt_s4[p])
		);
	end

	always_ff @(posedge clk) begin
		if (rdy_o && v_s4) begin
			culled_q <= |lt_s4;
		end
	end

	assign m_tdata = {(afc_pkg::M_TDATA_W - 1)'(0), culled_q};

`ifndef SYNTH
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3 && v_s4 && m_tvalid))
		else $error("input blocked while the pipeline has a bubble");

	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !rdy3) |=> v_s3)
		else $error("stage 3 beat lost during a stall");

	a_s4_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !rdy4) |=> v_s4)
		else $error("stage 4 beat lost during a stall");

	a_out_from_s4: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(v_s4))
		else $error("result raised without a stage 4 beat");
`endif

endmodule

`default_nettype wire
